// ===== sv/fcp_pkg.sv =====
// Shared constants and controller/datapath handshake types for the frame chunk packetizer.
// No dependencies.
package fcp_pkg;

    localparam int unsigned MAX_PACKET_BYTES = 1400;
    localparam int unsigned HDR_BYTES        = 8;
    localparam int unsigned MAX_PAYLOAD      = MAX_PACKET_BYTES - HDR_BYTES;

    localparam int unsigned PAY_W  = 11;
    localparam int unsigned LEN_W  = 24;
    localparam int unsigned DVD_W  = LEN_W + 1;
    localparam int unsigned FNUM_W = 32;
    localparam int unsigned PART_W = 16;
    localparam int unsigned HIDX_W = $clog2(HDR_BYTES);

    localparam logic [PAY_W-1:0] PAY_RESET = PAY_W'(MAX_PAYLOAD);

    // Header byte positions
    localparam logic [HIDX_W-1:0] HDR_FNUM3 = HIDX_W'(0);
    localparam logic [HIDX_W-1:0] HDR_FNUM2 = HIDX_W'(1);
    localparam logic [HIDX_W-1:0] HDR_FNUM1 = HIDX_W'(2);
    localparam logic [HIDX_W-1:0] HDR_FNUM0 = HIDX_W'(3);
    localparam logic [HIDX_W-1:0] HDR_PARTS1 = HIDX_W'(4);
    localparam logic [HIDX_W-1:0] HDR_PARTS0 = HIDX_W'(5);
    localparam logic [HIDX_W-1:0] HDR_PIDX1 = HIDX_W'(6);
    localparam logic [HIDX_W-1:0] HDR_PIDX0 = HIDX_W'(7);
    localparam logic [HIDX_W-1:0] HDR_LAST  = HDR_PIDX0;

    typedef struct packed {
        logic              capture;
        logic              div_start;
        logic              parts_load;
        logic              load_hdr;
        logic              load_data;
        logic [HIDX_W-1:0] hdr_idx;
    } ctrl_cmd_t;

    typedef struct packed {
        logic frame_start;
        logic pkt_start;
        logic out_free;
        logic div_done;
    } dp_status_t;

endpackage

// ===== sv/fcp_divider.sv =====
// Restoring divider, one quotient bit per cycle, for the per-frame part count.
// Depends on fcp_pkg.
module fcp_divider (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [fcp_pkg::DVD_W-1:0] dividend,
    input  logic [fcp_pkg::PAY_W-1:0] divisor,
    output logic                      done,
    output logic [fcp_pkg::DVD_W-1:0] quotient
);
    import fcp_pkg::*;

    localparam int unsigned CNT_W = $clog2(DVD_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [PAY_W-1:0] rem_reg, rem_next;
    logic [PAY_W-1:0] dsr_reg, dsr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [PAY_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift the quotient bit in where the dividend bit left
            dvd_next = {dvd_reg[DVD_W-2:0], fits};
            rem_next = fits ? PAY_W'(trial - {1'b0, dsr_reg}) : trial[PAY_W-1:0];
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

// ===== sv/fcp_datapath.sv =====
// Datapath: payload register, frame/packet counters, header byte select, output register.
// Depends on fcp_pkg and fcp_divider.
module fcp_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [fcp_pkg::PAY_W-1:0]  cfg_wr_data,
    input  logic [7:0]                 data_byte,
    input  logic [fcp_pkg::LEN_W-1:0]  frame_bytes,
    input  fcp_pkg::ctrl_cmd_t         cmd,
    output fcp_pkg::dp_status_t        status,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic [7:0]                 out_byte,
    output logic                       end_of_packet,
    output logic                       end_of_frame
);
    import fcp_pkg::*;

    logic [PAY_W-1:0]  payload_reg;
    logic [FNUM_W-1:0] fnum_reg;
    logic [PART_W-1:0] parts_reg;
    logic [PART_W-1:0] pidx_reg;
    logic [PAY_W-1:0]  bip_reg;
    logic [LEN_W-1:0]  bif_reg;
    logic [7:0]        data_reg;
    logic [LEN_W-1:0]  len_reg;
    logic              out_valid_reg;
    logic [7:0]        obyte_reg;
    logic              eop_reg;
    logic              eof_reg;

    logic [PAY_W-1:0]  pay_eff;
    logic [LEN_W-1:0]  len_in;
    logic [DVD_W-1:0]  dividend;
    logic              div_done;
    logic [DVD_W-1:0]  quotient;
    logic [LEN_W:0]    fcount;
    logic [PAY_W:0]    pcount;
    logic              eof;
    logic              eop;
    logic [7:0]        hdr_byte;

    // clamp the payload size to 1..MAX_PAYLOAD
    always_comb
    begin
        if (payload_reg == '0)
            pay_eff = PAY_W'(1);
        else if (payload_reg > PAY_RESET)
            pay_eff = PAY_RESET;
        else
            pay_eff = payload_reg;
    end

    assign len_in   = (frame_bytes == '0) ? LEN_W'(1) : frame_bytes;
    assign dividend = {1'b0, len_in} + DVD_W'(pay_eff) - DVD_W'(1);

    fcp_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (pay_eff),
        .done     (div_done),
        .quotient (quotient)
    );

    assign fcount = {1'b0, bif_reg} + (LEN_W+1)'(1);
    assign pcount = {1'b0, bip_reg} + (PAY_W+1)'(1);
    assign eof    = fcount >= {1'b0, len_reg};
    assign eop    = eof || (pcount >= {1'b0, pay_eff});

    always_comb
    begin
        unique case (cmd.hdr_idx)
            HDR_FNUM3:  hdr_byte = fnum_reg[31:24];
            HDR_FNUM2:  hdr_byte = fnum_reg[23:16];
            HDR_FNUM1:  hdr_byte = fnum_reg[15:8];
            HDR_FNUM0:  hdr_byte = fnum_reg[7:0];
            HDR_PARTS1: hdr_byte = parts_reg[15:8];
            HDR_PARTS0: hdr_byte = parts_reg[7:0];
            HDR_PIDX1:  hdr_byte = pidx_reg[15:8];
            HDR_PIDX0:  hdr_byte = pidx_reg[7:0];
            default:    hdr_byte = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            payload_reg   <= PAY_RESET;
            fnum_reg      <= '0;
            parts_reg     <= '0;
            pidx_reg      <= '0;
            bip_reg       <= '0;
            bif_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                payload_reg <= cfg_wr_data;

            if (cmd.parts_load)
            begin
                parts_reg <= quotient[PART_W-1:0];
                pidx_reg  <= '0;
                bip_reg   <= '0;
            end

            if (cmd.load_data)
            begin
                if (eof)
                begin
                    fnum_reg <= fnum_reg + FNUM_W'(1);
                    bif_reg  <= '0;
                    bip_reg  <= '0;
                    pidx_reg <= '0;
                end
                else
                begin
                    bif_reg <= fcount[LEN_W-1:0];
                    if (eop)
                    begin
                        bip_reg  <= '0;
                        pidx_reg <= pidx_reg + PART_W'(1);
                    end
                    else
                        bip_reg <= pcount[PAY_W-1:0];
                end
            end

            if (cmd.load_hdr || cmd.load_data)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            data_reg <= data_byte;
            len_reg  <= len_in;
        end
        if (cmd.load_hdr)
        begin
            obyte_reg <= hdr_byte;
            eop_reg   <= 1'b0;
            eof_reg   <= 1'b0;
        end
        else if (cmd.load_data)
        begin
            obyte_reg <= data_reg;
            eop_reg   <= eop;
            eof_reg   <= eof;
        end
    end

    assign status.frame_start = (bif_reg == '0);
    assign status.pkt_start   = (bip_reg == '0);
    assign status.out_free    = !out_valid_reg || out_ready;
    assign status.div_done    = div_done;

    assign out_valid     = out_valid_reg;
    assign out_byte      = obyte_reg;
    assign end_of_packet = eop_reg;
    assign end_of_frame  = eof_reg;

endmodule

// ===== sv/fcp_ctrl.sv =====
// Controller: sequences capture, part-count division, header beats and the payload beat.
// Depends on fcp_pkg.
module fcp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  fcp_pkg::dp_status_t status,
    output fcp_pkg::ctrl_cmd_t  cmd
);
    import fcp_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_HDR  = 2'd2;
    localparam logic [1:0] ST_DATA = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [HIDX_W-1:0] hidx_reg, hidx_next;
    logic              accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next     = state_reg;
        hidx_next      = hidx_reg;
        cmd            = '0;
        cmd.hdr_idx    = hidx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.capture = 1'b1;
                    hidx_next   = '0;
                    priority if (status.frame_start)
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = ST_DIV;
                    end
                    else if (status.pkt_start)
                        state_next = ST_HDR;
                    else
                        state_next = ST_DATA;
                end
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    cmd.parts_load = 1'b1;
                    state_next     = ST_HDR;
                end
            end
            ST_HDR:
            begin
                // one header beat each time the output register frees up
                if (status.out_free)
                begin
                    cmd.load_hdr = 1'b1;
                    hidx_next    = hidx_reg + HIDX_W'(1);
                    if (hidx_reg == HDR_LAST)
                        state_next = ST_DATA;
                end
            end
            ST_DATA:
            begin
                if (status.out_free)
                begin
                    cmd.load_data = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            hidx_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            hidx_reg  <= hidx_next;
        end
    end

endmodule

// ===== sv/frame_chunk_packetizer.sv =====
// Frame chunk packetizer: cuts a byte stream per frame into packets with an 8-byte header.
// Depends on fcp_pkg, fcp_ctrl and fcp_datapath.
//
// Input channel (in_valid/in_ready): one frame byte per beat, data_byte with frame_bytes,
// the frame's total length (0 is taken as 1). Output channel (out_valid/out_ready): one
// packet byte per beat with end_of_packet and end_of_frame marks. Before the first
// payload byte of each packet come 8 header bytes, big-endian: frame number (32 bits),
// part count ceil(length/payload) truncated to 16 bits, and part index (16 bits).
// cfg_wr_en/cfg_wr_data set the payload size per packet (0 acts as 1, above 1392 acts
// as 1392); write it only while no byte is in flight.
// The block takes one byte at a time. A byte inside a packet is loaded straight into the output
// register; a byte that opens a packet first sends 8 header beats through the single output
// register; a byte that opens a frame also waits for the bit-serial divider that forms the part
// count (25 quotient bits plus the load).
// After reset the frame number and all counters are zero and the payload size is 1392.
// When the receiver stalls the output beat holds and the sequencer waits; in_ready stays
// low until the current byte has been placed in the output register.
module frame_chunk_packetizer (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [fcp_pkg::PAY_W-1:0]  cfg_wr_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [7:0]                 data_byte,
    input  logic [fcp_pkg::LEN_W-1:0]  frame_bytes,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [7:0]                 out_byte,
    output logic                       end_of_packet,
    output logic                       end_of_frame
);
    import fcp_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    fcp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    fcp_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .data_byte     (data_byte),
        .frame_bytes   (frame_bytes),
        .cmd           (cmd),
        .status        (status),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .out_byte      (out_byte),
        .end_of_packet (end_of_packet),
        .end_of_frame  (end_of_frame)
    );

endmodule

// ===== tb/frame_chunk_packetizer_tb.sv =====
// Self-checking testbench for frame_chunk_packetizer: header insertion and packet cutting.
// Depends on fcp_pkg and the frame_chunk_packetizer RTL; a built-in predictor supplies the
// expected beats.
module frame_chunk_packetizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fcp_pkg::*;

    typedef struct packed {
        logic [7:0]       data;
        logic [LEN_W-1:0] len;
    } src_byte_t;

    typedef struct packed {
        logic [7:0] val;
        logic       eop;
        logic       eof;
    } pkt_beat_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_wr_en = 1'b0;
    logic [PAY_W-1:0] cfg_wr_data = '0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    logic [7:0]       data_byte = '0;
    logic [LEN_W-1:0] frame_bytes = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [7:0]       out_byte;
    logic             end_of_packet;
    logic             end_of_frame;

    // Stimulus and expected beats
    src_byte_t src_bytes[$];
    pkt_beat_t due_beats[$];

    // Predictor state
    logic [PAY_W-1:0]  cfg_payload = PAY_RESET;
    logic [FNUM_W-1:0] frame_num = '0;
    logic [PART_W-1:0] parts_in_frame = '0;
    logic [PART_W-1:0] part_idx = '0;
    int unsigned       packet_taken = 0;
    int unsigned       frame_taken = 0;

    bit quiet = 1'b0;
    bit hold_req = 1'b0;
    bit hold_taken = 1'b0;
    int hold_cycles = 0;

    int mismatches = 0;
    int bytes_in = 0;
    int beats_seen = 0;
    int frames_done = 0;
    int packets_done = 0;
    int settings_used = 0;

    frame_chunk_packetizer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .frame_bytes   (frame_bytes),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .end_of_packet (end_of_packet),
        .end_of_frame  (end_of_frame)
    );

    always #5 clk = ~clk;

    // Work out the packet beats caused by one accepted frame byte
    function automatic void packetize_byte(input logic [7:0] d, input logic [LEN_W-1:0] len_in);
        int unsigned len;
        int unsigned pay;
        int unsigned fcount;
        int unsigned pcount;
        logic        eop;
        logic        eof;
        logic [63:0] hdr;
        int          i;
        len = (len_in == '0) ? 1 : len_in;
        pay = (cfg_payload == '0) ? 1 : (cfg_payload > MAX_PAYLOAD) ? MAX_PAYLOAD : cfg_payload;
        if (frame_taken == 0)
        begin
            parts_in_frame = PART_W'((len + pay - 1) / pay);
            part_idx = '0;
            packet_taken = 0;
        end
        if (packet_taken == 0)
        begin
            hdr = {frame_num, parts_in_frame, part_idx};
            for (i = 7; i >= 0; i--)
                due_beats.push_back(pkt_beat_t'{hdr[8*i +: 8], 1'b0, 1'b0});
        end
        fcount = frame_taken + 1;
        pcount = packet_taken + 1;
        eof = (fcount >= len);
        eop = eof || (pcount >= pay);
        due_beats.push_back(pkt_beat_t'{d, eop, eof});
        if (eop)
            packets_done++;
        if (eof)
        begin
            frame_num++;
            frame_taken = 0;
            packet_taken = 0;
            part_idx = '0;
            frames_done++;
        end
        else
        begin
            frame_taken = fcount;
            if (eop)
            begin
                packet_taken = 0;
                part_idx++;
            end
            else
                packet_taken = pcount;
        end
    endfunction

    function automatic void queue_frame(input logic [LEN_W-1:0] len, input int count);
        repeat (count)
            src_bytes.push_back(src_byte_t'{8'($urandom), len});
    endfunction

    // Driver: hold the byte until accepted, then offer the next one or idle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            data_byte <= '0;
            frame_bytes <= '0;
        end
        else
        begin : drive
            src_byte_t nxt;
            logic      holding;
            holding = in_valid && !in_ready;
            if (in_valid && in_ready)
            begin
                packetize_byte(data_byte, frame_bytes);
                bytes_in++;
            end
            if (!holding)
            begin
                if (src_bytes.size() != 0 && (quiet || $urandom_range(99) >= 32))
                begin
                    nxt = src_bytes.pop_front();
                    in_valid <= 1'b1;
                    data_byte <= nxt.data;
                    frame_bytes <= nxt.len;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each output beat against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin : watch
            pkt_beat_t want;
            if (out_valid && out_ready)
            begin
                beats_seen++;
                if (due_beats.size() == 0)
                begin
                    $display("%0t: unexpected beat, byte %02h eop %0b eof %0b",
                             $time, out_byte, end_of_packet, end_of_frame);
                    mismatches++;
                end
                else
                begin
                    want = due_beats.pop_front();
                    if (out_byte !== want.val)
                    begin
                        $display("%0t: out_byte expected %02h got %02h",
                                 $time, want.val, out_byte);
                        mismatches++;
                    end
                    if (end_of_packet !== want.eop)
                    begin
                        $display("%0t: end_of_packet expected %0b got %0b",
                                 $time, want.eop, end_of_packet);
                        mismatches++;
                    end
                    if (end_of_frame !== want.eof)
                    begin
                        $display("%0t: end_of_frame expected %0b got %0b",
                                 $time, want.eof, end_of_frame);
                        mismatches++;
                    end
                end
            end
            // Long hold-off so the packetizer backs up and drops in_ready
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_cycles = 400;
            end
            if (hold_cycles != 0)
            begin
                hold_cycles--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= quiet || ($urandom_range(99) >= 32);
        end
    end

    // Wait until every byte is taken and every beat has arrived, then let the block rest;
    // look between rising edges so the driver's updates have all landed
    task automatic settle();
        @(negedge clk);
        while (src_bytes.size() != 0 || in_valid || due_beats.size() != 0)
            @(negedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_payload(input logic [PAY_W-1:0] v);
        settle();
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cfg_payload = v;
        settings_used++;
    endtask

    initial
    begin
        int               phase;
        int               queued;
        int               kind;
        int               k;
        logic [LEN_W-1:0] len;
        logic [PAY_W-1:0] pay;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset payload size: single-byte frames, zero length, huge length cut short
        src_bytes.push_back(src_byte_t'{8'h00, 24'd1});
        src_bytes.push_back(src_byte_t'{8'hFF, 24'd0});
        src_bytes.push_back(src_byte_t'{8'hA5, 24'hFFFFFF});
        src_bytes.push_back(src_byte_t'{8'h5A, 24'd2});

        // Zero payload acts as one byte; part count truncates to 16 bits
        write_payload('0);
        src_bytes.push_back(src_byte_t'{8'h3C, 24'hFFFFFF});
        src_bytes.push_back(src_byte_t'{8'hC3, 24'd1});
        queue_frame(24'd3, 3);

        // Oversized payloads clamp to the maximum
        write_payload('1);
        queue_frame(24'd2, 2);
        write_payload(PAY_W'(MAX_PAYLOAD + 1));
        queue_frame(24'd1, 1);

        // Change the payload size in the middle of a frame
        write_payload(PAY_W'(2));
        queue_frame(24'd5, 3);
        write_payload(PAY_W'(1));
        queue_frame(24'd5, 2);

        for (phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: pay = PAY_W'(1);
                1: pay = PAY_W'($urandom_range(2, 8));
                2: pay = PAY_W'(MAX_PAYLOAD);
                3: pay = '0;
                4: pay = PAY_W'($urandom_range(1, 2047));
                5: pay = '1;
                6: pay = PAY_W'($urandom_range(3, 40));
                default: pay = PAY_W'($urandom_range(1, 16));
            endcase
            write_payload(pay);
            quiet = (phase == 2);
            hold_req = (phase == 6);
            queued = 0;
            while (queued < 25)
            begin
                kind = $urandom_range(15);
                if (kind == 0)
                begin
                    queue_frame('0, 1);
                    queued += 1;
                end
                else if (kind <= 2)
                begin
                    // Broken frame: wild length first, then lengths that end it early
                    k = $urandom_range(0, 4);
                    src_bytes.push_back(src_byte_t'{8'($urandom), LEN_W'($urandom)});
                    repeat (k)
                        src_bytes.push_back(src_byte_t'{8'($urandom),
                                            LEN_W'($urandom_range(64, 24'hFFFFFF))});
                    src_bytes.push_back(src_byte_t'{8'($urandom),
                                        LEN_W'($urandom_range(0, k + 2))});
                    queued += k + 2;
                end
                else
                begin
                    len = LEN_W'($urandom_range(1, 48));
                    queue_frame(len, int'(len));
                    queued += int'(len);
                end
            end
        end

        settle();
        quiet = 1'b0;
        $display("Run took %0d frame bytes and checked %0d packet beats", bytes_in, beats_seen);
        $display("over %0d frames, %0d packets and %0d payload sizes",
                 frames_done, packets_done, settings_used + 1);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Timed out with %0d beats outstanding", due_beats.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
